### rtl/pqkr_pkg.sv
// pqkr_pkg: types, constants and helpers for the ordered process queue
// used by pqkr_ctrl, pqkr_dp and process_queue_keyed_removal; no dependencies
package pqkr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int REQ_W       = 3;
  localparam int STS_W       = 2;
  localparam int FIELD_ID_W  = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT    = 3'd0,
    REQ_PUSH_BACK     = 3'd1,
    REQ_POP_FRONT     = 3'd2,
    REQ_REMOVE_PID    = 3'd3,
    REQ_REMOVE_PARENT = 3'd4,
    REQ_FIND          = 3'd5
  } req_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } sts_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [FIELD_ID_W-1:0] pid;
    logic [FIELD_ID_W-1:0] parent_id;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0]      status;
    logic [FIELD_ID_W-1:0] out_pid;
    logic [FIELD_ID_W-1:0] out_parent;
    logic                  last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_req;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

  // physical slot of a logical position counted from the head of the ring
  function automatic logic [IDX_W-1:0] slot_addr(logic [IDX_W-1:0] head,
                                                 logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

### rtl/pqkr_ctrl.sv
// pqkr_ctrl: request sequencer for the ordered process queue
// depends on pqkr_pkg; drives pqkr_dp through ctrl_cmd_t / dp_sts_t
module pqkr_ctrl import pqkr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output ctrl_cmd_t cmd_o,
  input  dp_sts_t   sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.scan_req ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // final result waits for a free output register
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/pqkr_dp.sv
// pqkr_dp: slot memory, ring pointers, scan/compaction pipe and result register
// depends on pqkr_pkg; commanded by pqkr_ctrl
module pqkr_dp import pqkr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_sts_t   sts_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [ID_WIDTH-1:0] mem_pid [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] mem_par [QUEUE_DEPTH];

  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    occ_q, occ_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]    ev_idx_q, ev_idx_d;
  logic [CNT_W-1:0]    w_q, w_d;
  logic                ev_valid_q, ev_valid_d;
  logic [REQ_W-1:0]    op_q, op_d;
  logic [ID_WIDTH-1:0] key_q, key_d;
  logic [STS_W-1:0]    pend_sts_q, pend_sts_d;
  logic [ID_WIDTH-1:0] pend_pid_q, pend_pid_d;
  logic [ID_WIDTH-1:0] pend_par_q, pend_par_d;
  logic                pend_hit_q, pend_hit_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [ID_WIDTH-1:0] rd_pid_q, rd_par_q;

  logic                we, rd_en;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [ID_WIDTH-1:0] wpid, wpar;
  logic [ID_WIDTH-1:0] in_pid, in_par;
  logic                is_full, compact, match, stall, out_free, emit;
  logic                scan_req, scan_done;
  out_item_t           emit_item;

  assign in_pid   = ID_WIDTH'(in_item_i.pid);
  assign in_par   = ID_WIDTH'(in_item_i.parent_id);
  assign is_full  = (occ_q == CNT_W'(QUEUE_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (op_q) inside
      REQ_POP_FRONT, REQ_REMOVE_PID, REQ_REMOVE_PARENT: compact = 1'b1;
      default:                                          compact = 1'b0;
    endcase
  end

  always_comb begin
    case (in_item_i.req_type) inside
      REQ_POP_FRONT, REQ_REMOVE_PID, REQ_REMOVE_PARENT, REQ_FIND: scan_req = 1'b1;
      default:                                                   scan_req = 1'b0;
    endcase
  end

  // match on the entry held in the registered memory read data
  always_comb begin
    unique case (op_q)
      REQ_POP_FRONT:               match = (ev_idx_q == '0);
      REQ_REMOVE_PID, REQ_FIND:    match = (rd_pid_q == key_q) && !pend_hit_q;
      REQ_REMOVE_PARENT:           match = (rd_par_q == key_q);
      default:                     match = 1'b0;
    endcase
  end

  // a second hit must push the held one out first
  assign stall = ev_valid_q && match && pend_hit_q && !out_free;

  assign scan_done = !ev_valid_q && (rd_idx_q == occ_q);
  assign sts_o     = '{scan_req: scan_req, scan_done: scan_done, out_free: out_free};

  always_comb begin
    head_d     = head_q;
    occ_d      = occ_q;
    rd_idx_d   = rd_idx_q;
    ev_idx_d   = ev_idx_q;
    w_d        = w_q;
    ev_valid_d = ev_valid_q;
    op_d       = op_q;
    key_d      = key_q;
    pend_sts_d = pend_sts_q;
    pend_pid_d = pend_pid_q;
    pend_par_d = pend_par_q;
    pend_hit_d = pend_hit_q;
    we         = 1'b0;
    waddr      = slot_addr(head_q, w_q);
    wpid       = rd_pid_q;
    wpar       = rd_par_q;
    rd_en      = 1'b0;
    raddr      = slot_addr(head_q, rd_idx_q);
    emit       = 1'b0;
    emit_item.status     = pend_sts_q;
    emit_item.out_pid    = FIELD_ID_W'(pend_pid_q);
    emit_item.out_parent = FIELD_ID_W'(pend_par_q);
    emit_item.last       = 1'b1;

    if (cmd_i.load) begin
      op_d       = in_item_i.req_type;
      key_d      = (in_item_i.req_type == REQ_REMOVE_PARENT) ? in_par : in_pid;
      rd_idx_d   = '0;
      w_d        = '0;
      ev_valid_d = 1'b0;
      pend_hit_d = 1'b0;
      pend_sts_d = ST_NONE;
      pend_pid_d = '0;
      pend_par_d = '0;
      if (in_item_i.req_type == REQ_PUSH_FRONT || in_item_i.req_type == REQ_PUSH_BACK) begin
        if (is_full) begin
          pend_sts_d = ST_FULL;
        end else begin
          pend_sts_d = ST_OK;
          pend_pid_d = in_pid;
          pend_par_d = in_par;
          we         = 1'b1;
          wpid       = in_pid;
          wpar       = in_par;
          occ_d      = occ_q + CNT_W'(1);
          if (in_item_i.req_type == REQ_PUSH_FRONT) begin
            head_d = (head_q == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_q - IDX_W'(1);
            waddr  = head_d;
          end else begin
            waddr = slot_addr(head_q, occ_q);
          end
        end
      end
    end else if (cmd_i.scan) begin
      if (!stall) begin
        rd_en      = (rd_idx_q < occ_q);
        ev_valid_d = rd_en;
        ev_idx_d   = rd_idx_q;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (ev_valid_q) begin
          if (match) begin
            if (pend_hit_q) begin
              emit           = 1'b1;
              emit_item.last = 1'b0;
            end
            pend_hit_d = 1'b1;
            pend_sts_d = ST_OK;
            pend_pid_d = rd_pid_q;
            pend_par_d = rd_par_q;
          end else if (compact) begin
            // survivors slide towards the head
            we  = 1'b1;
            w_d = w_q + CNT_W'(1);
          end
        end
      end
    end else if (cmd_i.finish) begin
      emit = 1'b1;
      if (compact) begin
        occ_d = w_q;
      end
    end

    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      occ_q       <= '0;
      rd_idx_q    <= '0;
      w_q         <= '0;
      ev_valid_q  <= 1'b0;
      op_q        <= '0;
      pend_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      occ_q       <= occ_d;
      rd_idx_q    <= rd_idx_d;
      w_q         <= w_d;
      ev_valid_q  <= ev_valid_d;
      op_q        <= op_d;
      pend_hit_q  <= pend_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    key_q      <= key_d;
    pend_sts_q <= pend_sts_d;
    pend_pid_q <= pend_pid_d;
    pend_par_q <= pend_par_d;
    out_q      <= out_d;
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_pid[waddr] <= wpid;
      mem_par[waddr] <= wpar;
    end
    if (rd_en) begin
      rd_pid_q <= mem_pid[raddr];
      rd_par_q <= mem_par[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_write_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_q |-> (w_q <= ev_idx_q) && (ev_idx_q < occ_q))
    else $error("compaction write overtook the scan");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q && out_q.last)
    else $error("final result not loaded with last set");

endmodule

### rtl/process_queue_keyed_removal.sv
// Ordered process queue with keyed removal.
// Requests enter on in_valid_i/in_ready_o as in_item_t (req_type, pid, parent_id);
// results leave on out_valid_o/out_ready_i as out_item_t (status, ids, last).
// One request is worked at a time. Entries live in a ring of QUEUE_DEPTH slots
// held in a single-write, single-read memory.
// Push and unknown requests go from accept straight to the done state, where
// the result register is loaded once it is free. Pop, remove and find walk
// every valid slot through the memory read port, one slot a cycle unless a
// second hit waits for the output register; the final result is loaded as
// the controller returns to idle, where the next request can be taken.
// Remove by parent gives one result per removed entry in queue order, last on
// the final one; each result is held back until the next hit or the end of
// the walk so last can be set.
// The result sits in an output register: a stalled receiver does not block
// acceptance of the next request, but a request that produces a further
// result waits in place until the register is free.
// Reset (rst_ni low, asynchronous) empties the queue and clears all handshake
// state; slot contents are not cleared and are never read before written.
module process_queue_keyed_removal import pqkr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  pqkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pqkr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
